@@ design/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the image frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_MAX_NAME_LEN = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAY_LEN  = 1'd1;

  localparam logic [15:0] MAX_NAME_LEN_RST = 16'd256;
  localparam logic [31:0] MAX_PAY_LEN_RST  = 32'd20971520;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_NAME    = 3'd1;
  localparam logic [2:0] ROLE_PHDR    = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_DISCARD = 3'd4;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_GOOD    = 3'd1;
  localparam logic [2:0] ST_NOTJPEG = 3'd2;
  localparam logic [2:0] ST_MAGIC   = 3'd3;
  localparam logic [2:0] ST_NAMELEN = 3'd4;
  localparam logic [2:0] ST_PAYLEN  = 3'd5;

  localparam logic [7:0] MAGIC_0  = 8'h4B;
  localparam logic [7:0] MAGIC_1  = 8'h49;
  localparam logic [7:0] MAGIC_2  = 8'h4D;
  localparam logic [7:0] MAGIC_3  = 8'h47;
  localparam logic [7:0] JPEG_FF  = 8'hFF;
  localparam logic [7:0] JPEG_SOI = 8'hD8;
  localparam logic [7:0] JPEG_EOI = 8'hD9;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_role;
    logic        frame_end;
    logic [2:0]  status;
    logic [31:0] sequence_number;
    logic [15:0] name_length_out;
    logic [31:0] payload_length_out;
  } ifd_result_t;

endpackage

`default_nettype wire

@@ design/ifd_parser.sv @@
// ----------------------------------------------------------------------------
// ifd_parser
// Frame parser state and the per-beat result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 connection_start,
  input  wire logic [15:0]          max_name_length,
  input  wire logic [31:0]          max_payload_length,
  output ifd_pkg::ifd_result_t      result
);
  import ifd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_PHDR,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [31:0] cnt_r, cnt_nxt, cnt_cur;
  logic [15:0] nlen_r, nlen_nxt;
  logic [31:0] pay_len_r, pay_len_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        smo_r, smo_nxt;
  logic        magic_r, magic_nxt;
  logic [7:0]  prev_r;
  logic [7:0]  magic_byte;
  logic [32:0] cnt_inc;

  always_comb begin
    phase_cur = connection_start ? PH_HEADER : phase_r;
    cnt_cur   = connection_start ? 32'd0 : cnt_r;
    cnt_inc   = {1'b0, cnt_cur} + 33'd1;

    unique case (cnt_cur[1:0])
      2'd0:    magic_byte = MAGIC_0;
      2'd1:    magic_byte = MAGIC_1;
      2'd2:    magic_byte = MAGIC_2;
      default: magic_byte = MAGIC_3;
    endcase

    phase_nxt   = phase_cur;
    cnt_nxt     = cnt_cur;
    nlen_nxt    = nlen_r;
    pay_len_nxt = pay_len_r;
    seq_nxt     = seq_r;
    smo_nxt     = smo_r;
    magic_nxt   = magic_r;

    result.out_byte  = data_byte;
    result.byte_role = ROLE_DISCARD;
    result.frame_end = 1'b0;
    result.status    = ST_BUSY;

    unique case (phase_cur)
      PH_HEADER: begin
        result.byte_role = ROLE_HEADER;
        if (cnt_cur == 32'd0) begin
          nlen_nxt    = 16'd0;
          pay_len_nxt = 32'd0;
          seq_nxt     = 32'd0;
          smo_nxt     = 1'b0;
          magic_nxt   = 1'b1;
        end
        if (cnt_cur < 32'd4) begin
          if (data_byte != magic_byte) begin
            magic_nxt = 1'b0;
          end
          cnt_nxt = cnt_inc[31:0];
        end else if (cnt_cur == 32'd4) begin
          cnt_nxt = cnt_inc[31:0];
        end else begin
          nlen_nxt = {prev_r, data_byte};
          cnt_nxt  = 32'd0;
          if (!magic_nxt) begin
            result.frame_end = 1'b1;
            result.status    = ST_MAGIC;
            phase_nxt        = PH_DISCARD;
          end else if (nlen_nxt == 16'd0 || nlen_nxt > max_name_length) begin
            result.frame_end = 1'b1;
            result.status    = ST_NAMELEN;
            phase_nxt        = PH_DISCARD;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        result.byte_role = ROLE_NAME;
        cnt_nxt          = cnt_inc[31:0];
        if (cnt_inc >= {17'd0, nlen_r}) begin
          cnt_nxt   = 32'd0;
          phase_nxt = PH_PHDR;
        end
      end
      PH_PHDR: begin
        result.byte_role = ROLE_PHDR;
        if (cnt_cur < 32'd4) begin
          pay_len_nxt = {pay_len_r[23:0], data_byte};
        end else begin
          seq_nxt = {seq_r[23:0], data_byte};
        end
        cnt_nxt = cnt_inc[31:0];
        if (cnt_inc >= 33'd8) begin
          cnt_nxt = 32'd0;
          if (pay_len_nxt == 32'd0 || pay_len_nxt > max_payload_length) begin
            result.frame_end = 1'b1;
            result.status    = ST_PAYLEN;
            phase_nxt        = PH_DISCARD;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result.byte_role = ROLE_PAYLOAD;
        if (cnt_cur == 32'd1) begin
          smo_nxt = (prev_r == JPEG_FF) && (data_byte == JPEG_SOI);
        end
        if (cnt_inc >= {1'b0, pay_len_r}) begin
          result.frame_end = 1'b1;
          result.status    = (pay_len_r >= 32'd4 && smo_nxt && prev_r == JPEG_FF &&
                              data_byte == JPEG_EOI) ? ST_GOOD : ST_NOTJPEG;
          phase_nxt        = PH_HEADER;
          cnt_nxt          = 32'd0;
        end else begin
          cnt_nxt = cnt_inc[31:0];
        end
      end
      default: begin
        result.byte_role = ROLE_DISCARD;
        phase_nxt        = PH_DISCARD;
      end
    endcase

    result.sequence_number    = result.frame_end ? seq_nxt : 32'd0;
    result.name_length_out    = result.frame_end ? nlen_nxt : 16'd0;
    result.payload_length_out = result.frame_end ? pay_len_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      cnt_r     <= 32'd0;
      nlen_r    <= 16'd0;
      pay_len_r <= 32'd0;
      seq_r     <= 32'd0;
      smo_r     <= 1'b0;
      magic_r   <= 1'b1;
      prev_r    <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      nlen_r    <= nlen_nxt;
      pay_len_r <= pay_len_nxt;
      seq_r     <= seq_nxt;
      smo_r     <= smo_nxt;
      magic_r   <= magic_nxt;
      prev_r    <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/image_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// image_frame_deframer
// Parses a byte stream into frames and tags every byte with its role.
// Each accepted byte's result beat is registered and shows the next cycle.
// Throughput: one byte per cycle without out_stall; single result register.
// Reset: synchronous, active low; the parser returns to the frame header
// phase, the output register empties and both maxima take their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module image_frame_deframer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic                         in_connection_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_out_byte,
  output logic [2:0]                        out_byte_role,
  output logic                              out_frame_end,
  output logic [2:0]                        out_status,
  output logic [31:0]                       out_sequence_number,
  output logic [15:0]                       out_name_length_out,
  output logic [31:0]                       out_payload_length_out,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ifd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                  cfg_wdata
);
  import ifd_pkg::*;

  logic [15:0] max_name_r;
  logic [31:0] max_pay_r;
  logic        out_valid_r;
  ifd_result_t res_r;
  ifd_result_t res_nxt;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  ifd_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (accept),
    .data_byte          (in_data_byte),
    .connection_start   (in_connection_start),
    .max_name_length    (max_name_r),
    .max_payload_length (max_pay_r),
    .result             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r <= MAX_NAME_LEN_RST;
      max_pay_r  <= MAX_PAY_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_NAME_LEN: max_name_r <= cfg_wdata[15:0];
        default:          max_pay_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_out_byte           = res_r.out_byte;
  assign out_byte_role          = res_r.byte_role;
  assign out_frame_end          = res_r.frame_end;
  assign out_status             = res_r.status;
  assign out_sequence_number    = res_r.sequence_number;
  assign out_name_length_out    = res_r.name_length_out;
  assign out_payload_length_out = res_r.payload_length_out;

endmodule

`default_nettype wire
